// ===== rtl/cbop_pkg.sv =====
// Shared types and constants for the box corners outside polygon test.
package cbop_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int CORNER_COUNT     = 4;
    localparam int COORD_W          = 16;
    localparam int POINT_W          = 18;
    localparam int CFG_W            = 7;
    localparam int IDX_W            = 6;
    localparam int SIZE_W           = 15;
    localparam int DRAIN_CYCLES     = 10;
    localparam int DRAIN_W          = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] xj;
        logic signed [COORD_W-1:0] yj;
        logic signed [COORD_W-1:0] xk;
        logic signed [COORD_W-1:0] yk;
    } t_edge;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

// ===== rtl/box_corners_outside_polygon_test.sv =====
// Top level: polygon store, edge sequencer and the row of corner cells.
//
// Usage: items enter on the input channel (i_in_valid / o_in_stall). A write
// item (opcode 0) stores one polygon vertex and is acknowledged with one
// result carrying was_query 0 and hit 0. A query item (opcode 1) gives a box;
// its result carries was_query 1 and hit 1 when some box corner lies outside
// the polygon. Results leave on the output channel (o_out_valid /
// i_out_stall) through an output register that holds while stalled.
// The vertex count register is written on the configuration channel
// (i_cfg_valid / o_cfg_ready, always ready); the user must write it only
// while the block is idle, as the block does not enforce this. A write's
// result appears in the cycle after it is taken. A query reads the vertex
// store one entry per cycle, starting from the last vertex, and each edge
// streams through the four corner cells; the result loads after the drain.
// One item is worked on at a time; the next is taken once the result register
// is free or being emptied. Reset empties the result register, returns the
// sequencer to idle and sets the vertex count to 3; the vertex store keeps
// no reset value and must be written before it is queried.
module box_corners_outside_polygon_test #(
    parameter int MAX_VERTICES = cbop_pkg::MAX_VERTICES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [cbop_pkg::IDX_W-1:0]          i_vertex_index,
    input  logic signed [cbop_pkg::COORD_W-1:0] i_vertex_x,
    input  logic signed [cbop_pkg::COORD_W-1:0] i_vertex_y,
    input  logic signed [cbop_pkg::COORD_W-1:0] i_box_left,
    input  logic signed [cbop_pkg::COORD_W-1:0] i_box_top,
    input  logic [cbop_pkg::SIZE_W-1:0]         i_box_width,
    input  logic [cbop_pkg::SIZE_W-1:0]         i_box_height,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_was_query,
    output logic                                o_hit,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cbop_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1) + 1;
    localparam int CRN = cbop_pkg::CORNER_COUNT;
    localparam int CO = cbop_pkg::COORD_W;
    localparam int PT = cbop_pkg::POINT_W;

    cbop_pkg::t_state r_state, n_state;

    logic [cbop_pkg::CFG_W-1:0] r_count;
    logic [CW-1:0]              r_rd_cnt, n_total, n_vert;
    logic [cbop_pkg::DRAIN_W-1:0] r_drain;
    logic                       r_rd_pend, r_have_prev;
    logic signed [CO-1:0]       r_prev_x, r_prev_y;
    cbop_pkg::t_edge            r_edge;
    logic                       r_out_valid, r_was_query, r_hit;

    logic accept, out_free, load_q, re, we, run_done, drain_done, ld_result;
    logic [AW-1:0] raddr, waddr;
    logic [2*CO-1:0] rdata;
    logic [CW-1:0] step_addr;

    logic signed [PT-1:0] px [CRN];
    logic signed [PT-1:0] py [CRN];
    cbop_pkg::t_edge      chain [CRN+1];
    logic [CRN-1:0]       corner_in;

    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = i_in_valid && !o_in_stall;
    assign load_q   = accept && (i_opcode == cbop_pkg::OP_QUERY);
    assign we       = accept && (i_opcode == cbop_pkg::OP_WRITE) &&
                      (32'(i_vertex_index) < MAX_VERTICES);
    assign waddr    = AW'(32'(i_vertex_index));

    always_comb begin
        if (32'(r_count) > MAX_VERTICES) begin
            n_vert = CW'(MAX_VERTICES);
        end else begin
            n_vert = CW'(r_count);
        end
        n_total    = (n_vert == '0) ? '0 : n_vert + CW'(1);
        step_addr  = (r_rd_cnt == '0) ? n_vert - CW'(1) : r_rd_cnt - CW'(1);
        raddr      = AW'(step_addr);
        run_done   = (r_rd_cnt == n_total);
        drain_done = (r_drain == cbop_pkg::DRAIN_W'(cbop_pkg::DRAIN_CYCLES - 1));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cbop_pkg::S_IDLE:  if (load_q) n_state = cbop_pkg::S_RUN;
            cbop_pkg::S_RUN:   if (run_done) n_state = cbop_pkg::S_DRAIN;
            cbop_pkg::S_DRAIN: if (drain_done) n_state = cbop_pkg::S_DONE;
            cbop_pkg::S_DONE:  if (out_free) n_state = cbop_pkg::S_IDLE;
            default:           n_state = cbop_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        re         = 1'b0;
        ld_result  = 1'b0;
        case (r_state)
            cbop_pkg::S_IDLE:  o_in_stall = !out_free;
            cbop_pkg::S_RUN:   re = !run_done;
            cbop_pkg::S_DRAIN: re = 1'b0;
            cbop_pkg::S_DONE:  ld_result = out_free;
            default:           o_in_stall = 1'b1;
        endcase
    end

    always_comb begin
        px[0] = PT'(i_box_left);
        py[0] = PT'(i_box_top);
        px[1] = PT'(i_box_left) + PT'(i_box_width);
        py[1] = PT'(i_box_top);
        px[2] = PT'(i_box_left);
        py[2] = PT'(i_box_top) + PT'(i_box_height);
        px[3] = PT'(i_box_left) + PT'(i_box_width);
        py[3] = PT'(i_box_top) + PT'(i_box_height);
    end

    cbop_ram #(
        .WIDTH (2 * CO),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({i_vertex_x, i_vertex_y}),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign chain[0] = r_edge;

    for (genvar g = 0; g < CRN; g++) begin : g_cell
        cbop_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (load_q),
            .i_px     (px[g]),
            .i_py     (py[g]),
            .i_edge   (chain[g]),
            .o_edge   (chain[g+1]),
            .o_inside (corner_in[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_prev_x  <= $signed(rdata[2*CO-1:CO]);
            r_prev_y  <= $signed(rdata[CO-1:0]);
            r_edge.xj <= $signed(rdata[2*CO-1:CO]);
            r_edge.yj <= $signed(rdata[CO-1:0]);
            r_edge.xk <= r_prev_x;
            r_edge.yk <= r_prev_y;
        end
        if (ld_result) begin
            r_was_query <= 1'b1;
            r_hit       <= ~&corner_in;
        end else if (accept && (i_opcode == cbop_pkg::OP_WRITE)) begin
            r_was_query <= 1'b0;
            r_hit       <= 1'b0;
        end
        if (!i_rst_n) begin
            r_state      <= cbop_pkg::S_IDLE;
            r_count      <= cbop_pkg::CFG_W'(3);
            r_rd_cnt     <= '0;
            r_drain      <= '0;
            r_rd_pend    <= 1'b0;
            r_have_prev  <= 1'b0;
            r_edge.valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            r_rd_pend <= re;
            if (load_q) begin
                r_rd_cnt    <= '0;
                r_have_prev <= 1'b0;
            end else if (re) begin
                r_rd_cnt <= r_rd_cnt + CW'(1);
            end
            if (r_rd_pend) begin
                r_have_prev <= 1'b1;
            end
            r_edge.valid <= r_rd_pend && r_have_prev;
            if (r_state == cbop_pkg::S_DRAIN) begin
                r_drain <= r_drain + cbop_pkg::DRAIN_W'(1);
            end else begin
                r_drain <= '0;
            end
            if (ld_result || (accept && (i_opcode == cbop_pkg::OP_WRITE))) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_was_query = r_was_query;
    assign o_hit       = r_hit;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== rtl/cbop_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module cbop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cbop_cell.sv =====
// One corner cell: holds a corner and its crossing parity, passes edges on.
module cbop_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  logic signed [cbop_pkg::POINT_W-1:0]   i_px,
    input  logic signed [cbop_pkg::POINT_W-1:0]   i_py,
    input  cbop_pkg::t_edge                       i_edge,
    output cbop_pkg::t_edge                       o_edge,
    output logic                                  o_inside
);

    localparam int DW = cbop_pkg::POINT_W + 1;
    localparam int EW = cbop_pkg::COORD_W + 1;
    localparam int PW = DW + EW;

    logic signed [cbop_pkg::POINT_W-1:0] r_px, r_py;
    cbop_pkg::t_edge                     r_edge;

    logic                 r_s1_cross;
    logic signed [DW-1:0] r_a, r_c;
    logic signed [EW-1:0] r_dy, r_b;

    logic                 r_s2_cross, r_s2_pos;
    logic signed [PW-1:0] r_lhs, r_rhs;

    logic r_inside;
    logic n_cross;
    logic n_left;

    always_comb begin
        n_cross = i_edge.valid &&
                  (($signed(DW'(i_edge.yj)) > $signed(DW'(r_py))) !=
                   ($signed(DW'(i_edge.yk)) > $signed(DW'(r_py))));
        n_left  = r_s2_pos ? (r_lhs < r_rhs) : (r_lhs > r_rhs);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_px <= i_px;
            r_py <= i_py;
        end
        r_edge.xj <= i_edge.xj;
        r_edge.yj <= i_edge.yj;
        r_edge.xk <= i_edge.xk;
        r_edge.yk <= i_edge.yk;
        r_a   <= DW'(r_px) - DW'(i_edge.xj);
        r_c   <= DW'(r_py) - DW'(i_edge.yj);
        r_dy  <= EW'(i_edge.yk) - EW'(i_edge.yj);
        r_b   <= EW'(i_edge.xk) - EW'(i_edge.xj);
        r_lhs <= PW'(r_a) * PW'(r_dy);
        r_rhs <= PW'(r_b) * PW'(r_c);
        r_s2_pos <= (r_dy > 0);
        if (!i_rst_n) begin
            r_edge.valid <= 1'b0;
            r_s1_cross   <= 1'b0;
            r_s2_cross   <= 1'b0;
            r_inside     <= 1'b0;
        end else begin
            r_edge.valid <= i_edge.valid;
            r_s1_cross   <= n_cross;
            r_s2_cross   <= r_s1_cross;
            if (i_load) begin
                r_inside <= 1'b0;
            end else if (r_s2_cross && n_left) begin
                r_inside <= ~r_inside;
            end
        end
    end

    assign o_edge   = r_edge;
    assign o_inside = r_inside;

endmodule
